// ----- hdl/kvt_pkg.sv -----
// Shared types and codes for the key/value table engine.
package kvt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned WORD_W      = 64;

  localparam logic [1:0] OP_GET  = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_LIST = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] read_value;
    logic [WORD_W-1:0] listed_key;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic key_we;
    logic value_we;
    logic valid_set;
    logic valid_clr;
  } wr_cmd_t;

endpackage

// ----- hdl/kvt_store.sv -----
// Slot storage: key and value memories, valid flags and fill count.
module kvt_store #(
  parameter int unsigned ENTRIES = kvt_pkg::ENTRIES_DEF,
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [kvt_pkg::WORD_W-1:0] rd_key_o,
  output logic [kvt_pkg::WORD_W-1:0] rd_value_o,
  output logic                      rd_valid_o,
  input  kvt_pkg::wr_cmd_t          wr_cmd_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [kvt_pkg::WORD_W-1:0] wr_key_i,
  input  logic [kvt_pkg::WORD_W-1:0] wr_value_i,
  output logic [CW-1:0]             count_o
);

  logic [kvt_pkg::WORD_W-1:0] key_mem_q   [ENTRIES];
  logic [kvt_pkg::WORD_W-1:0] value_mem_q [ENTRIES];
  logic [ENTRIES-1:0]         valid_q;
  logic [CW-1:0]              count_q;
  logic [kvt_pkg::WORD_W-1:0] rd_key_q;
  logic [kvt_pkg::WORD_W-1:0] rd_value_q;
  logic                       rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_cmd_i.key_we) begin
      key_mem_q[wr_addr_i] <= wr_key_i;
    end
    if (wr_cmd_i.value_we) begin
      value_mem_q[wr_addr_i] <= wr_value_i;
    end
    if (rd_en_i) begin
      rd_key_q   <= key_mem_q[rd_addr_i];
      rd_value_q <= value_mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      count_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
      if (wr_cmd_i.valid_set) begin
        valid_q[wr_addr_i] <= 1'b1;
        count_q            <= count_q + CW'(1);
      end else if (wr_cmd_i.valid_clr) begin
        valid_q[wr_addr_i] <= 1'b0;
        count_q            <= count_q - CW'(1);
      end
    end
  end

  assign rd_key_o   = rd_key_q;
  assign rd_value_o = rd_value_q;
  assign rd_valid_o = rd_valid_q;
  assign count_o    = count_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("fill count exceeds capacity");
  a_set_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_cmd_i.valid_set && wr_cmd_i.valid_clr))
    else $error("slot set and cleared together");
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cmd_i.valid_set |-> (count_q < CW'(ENTRIES)) && !valid_q[wr_addr_i])
    else $error("insert into full table or occupied slot");
`endif

endmodule

// ----- hdl/kvt_seq.sv -----
// Command sequencer: scans the slots through the store and builds results.
module kvt_seq #(
  parameter int unsigned ENTRIES = kvt_pkg::ENTRIES_DEF,
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  kvt_pkg::req_t              req_i,
  output logic                       busy,
  output logic                       rsp_valid_o,
  output kvt_pkg::rsp_t              rsp_o,
  output logic                       rd_en_o,
  output logic [AW-1:0]              rd_addr_o,
  input  logic [kvt_pkg::WORD_W-1:0] rd_key_i,
  input  logic [kvt_pkg::WORD_W-1:0] rd_value_i,
  input  logic                       rd_valid_i,
  output kvt_pkg::wr_cmd_t           wr_cmd_o,
  output logic [AW-1:0]              wr_addr_o,
  output logic [kvt_pkg::WORD_W-1:0] wr_key_o,
  output logic [kvt_pkg::WORD_W-1:0] wr_value_o,
  input  logic [CW-1:0]              count_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  logic [1:0]                 state_q, state_d;
  kvt_pkg::req_t              req_q, req_d;
  logic                       iss_act_q, iss_act_d;
  logic [AW-1:0]              iss_addr_q, iss_addr_d;
  logic                       cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]              cmp_idx_q, cmp_idx_d;
  logic                       cmp_last_q, cmp_last_d;
  logic                       free_q, free_d;
  logic [AW-1:0]              free_idx_q, free_idx_d;
  logic                       pend_q, pend_d;
  logic [kvt_pkg::WORD_W-1:0] pend_key_q, pend_key_d;
  logic                       rsp_vld_q, rsp_vld_d;
  kvt_pkg::rsp_t              rsp_q, rsp_d;
  logic                       hit;

  assign hit = rd_valid_i && (rd_key_i == req_q.key);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    iss_act_d  = iss_act_q;
    iss_addr_d = iss_addr_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    cmp_last_d = cmp_last_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    pend_d     = pend_q;
    pend_key_d = pend_key_q;
    rsp_vld_d  = 1'b0;
    rsp_d      = '0;
    wr_cmd_o   = '0;
    wr_addr_o  = cmp_idx_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = iss_addr_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d      = req_i;
          state_d    = S_SCAN;
          iss_act_d  = 1'b1;
          iss_addr_d = '0;
          free_d     = 1'b0;
          pend_d     = 1'b0;
        end
      end
      S_SCAN: begin
        // issue one slot read per cycle
        if (iss_act_q) begin
          rd_en_o    = 1'b1;
          cmp_vld_d  = 1'b1;
          cmp_idx_d  = iss_addr_q;
          cmp_last_d = (iss_addr_q == LAST_ADDR);
          iss_addr_d = iss_addr_q + AW'(1);
          if (iss_addr_q == LAST_ADDR) begin
            iss_act_d = 1'b0;
          end
        end
        if (cmp_vld_q) begin
          if (req_q.opcode != kvt_pkg::OP_LIST && hit) begin
            // first match ends the scan; drop the reads still in flight
            rsp_vld_d       = 1'b1;
            rsp_d.status    = kvt_pkg::ST_OK;
            rsp_d.last      = 1'b1;
            if (req_q.opcode == kvt_pkg::OP_GET) begin
              rsp_d.read_value = rd_value_i;
            end
            wr_cmd_o.value_we  = (req_q.opcode == kvt_pkg::OP_SET);
            wr_cmd_o.valid_clr = (req_q.opcode == kvt_pkg::OP_DEL);
            state_d   = S_IDLE;
            iss_act_d = 1'b0;
            cmp_vld_d = 1'b0;
          end else begin
            if (!rd_valid_i && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = cmp_idx_q;
            end
            // hold each listed key back one step so the final one carries last
            if (req_q.opcode == kvt_pkg::OP_LIST && rd_valid_i) begin
              if (pend_q) begin
                rsp_vld_d        = 1'b1;
                rsp_d.status     = kvt_pkg::ST_OK;
                rsp_d.listed_key = pend_key_q;
              end
              pend_d     = 1'b1;
              pend_key_d = rd_key_i;
            end
            if (cmp_last_q) begin
              if (req_q.opcode == kvt_pkg::OP_LIST) begin
                state_d = S_FLUSH;
              end else begin
                state_d      = S_IDLE;
                rsp_vld_d    = 1'b1;
                rsp_d.last   = 1'b1;
                rsp_d.status = kvt_pkg::ST_MISS;
                if (req_q.opcode == kvt_pkg::OP_SET) begin
                  if (count_i == CW'(ENTRIES)) begin
                    rsp_d.status = kvt_pkg::ST_FULL;
                  end else if (free_q || !rd_valid_i) begin
                    rsp_d.status       = kvt_pkg::ST_OK;
                    wr_cmd_o.key_we    = 1'b1;
                    wr_cmd_o.value_we  = 1'b1;
                    wr_cmd_o.valid_set = 1'b1;
                    wr_addr_o          = free_q ? free_idx_q : cmp_idx_q;
                  end else begin
                    rsp_d.status = kvt_pkg::ST_FULL;
                  end
                end
              end
            end
          end
        end
      end
      S_FLUSH: begin
        rsp_vld_d  = 1'b1;
        rsp_d.last = 1'b1;
        if (pend_q) begin
          rsp_d.status     = kvt_pkg::ST_OK;
          rsp_d.listed_key = pend_key_q;
        end else begin
          rsp_d.status = kvt_pkg::ST_MISS;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      iss_act_q <= 1'b0;
      cmp_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_act_q <= iss_act_d;
      cmp_vld_q <= cmp_vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    iss_addr_q <= iss_addr_d;
    cmp_idx_q  <= cmp_idx_d;
    cmp_last_q <= cmp_last_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    pend_q     <= pend_d;
    pend_key_q <= pend_key_d;
    rsp_q      <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;
  assign wr_key_o    = req_q.key;
  assign wr_value_o  = req_q.value;

`ifndef SYNTHESIS
  a_last_ends_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && rsp_q.last) |-> (state_q == S_IDLE))
    else $error("final result while command still active");
  a_only_list_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && !rsp_q.last) |-> (req_q.opcode == kvt_pkg::OP_LIST))
    else $error("non-final result outside list");
  a_one_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> ((rsp_q.read_value == '0) || (rsp_q.listed_key == '0)))
    else $error("value and key both set in one result");
`endif

endmodule

// ----- hdl/key_value_table_engine.sv -----
// Top level of the key/value table engine: sequencer plus slot store.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------
//  command   | start, busy          | req_i  (opcode, key, value)
//  result    | rsp_valid_o (strobe) | rsp_o  (status, read_value,
//            |                      |         listed_key, last)
//
// A command is taken when start is high and busy is low. It reads one slot
// per cycle from the key/value memories through one registered read port;
// get, set and delete stop at the first match; list flushes its final key.
// Reset clears the valid flags and the fill count at once; no clearing pass.
// Results are strobed for one cycle and cannot be held off.
module key_value_table_engine #(
  parameter int unsigned ENTRIES = kvt_pkg::ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  kvt_pkg::req_t req_i,
  output logic          busy,
  output logic          rsp_valid_o,
  output kvt_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [kvt_pkg::WORD_W-1:0] rd_key;
  logic [kvt_pkg::WORD_W-1:0] rd_value;
  logic                       rd_valid;
  kvt_pkg::wr_cmd_t           wr_cmd;
  logic [AW-1:0]              wr_addr;
  logic [kvt_pkg::WORD_W-1:0] wr_key;
  logic [kvt_pkg::WORD_W-1:0] wr_value;
  logic [CW-1:0]              count;

  kvt_seq #(
    .ENTRIES(ENTRIES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_key_i   (rd_key),
    .rd_value_i (rd_value),
    .rd_valid_i (rd_valid),
    .wr_cmd_o   (wr_cmd),
    .wr_addr_o  (wr_addr),
    .wr_key_o   (wr_key),
    .wr_value_o (wr_value),
    .count_i    (count)
  );

  kvt_store #(
    .ENTRIES(ENTRIES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key),
    .rd_value_o(rd_value),
    .rd_valid_o(rd_valid),
    .wr_cmd_i  (wr_cmd),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .wr_value_i(wr_value),
    .count_o   (count)
  );

endmodule
